// ----- src/stuffed_crc_frame_decoder_unit_defines.svh -----
// Assertion macros shared by the checker of the frame decoder
`ifndef STUFFED_CRC_FRAME_DECODER_UNIT_DEFINES_SVH
`define STUFFED_CRC_FRAME_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, held off during reset
`define SCFD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scfd checker: same-cycle property failed");

// Next-cycle implication, sampled on i_clk, held off during reset
`define SCFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scfd checker: next-cycle property failed");

`endif

// ----- src/scfd_pkg.sv -----
// Types, codes and the CRC step shared by the frame decoder modules
`default_nettype none

package scfd_pkg;

    // Framing phase kept by the front end
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC_HI  = 3'd4,
        PH_CRC_LO  = 3'd5
    } t_phase;

    // Role of a de-stuffed byte handed from front to back
    typedef enum logic [2:0] {
        TK_LEN_HI  = 3'd0,
        TK_LEN_LO  = 3'd1,
        TK_LEN_BAD = 3'd2,
        TK_PAYLOAD = 3'd3,
        TK_CRC_HI  = 3'd4,
        TK_CRC_LO  = 3'd5
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind  kind;
        logic [7:0] data;
    } t_token;

    localparam int TOKEN_W = $bits(t_token);

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  escape_byte;
        logic [7:0]  escape_mask;
        logic [15:0] max_payload;
    } t_cfg;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_BYTE  = 2'd0;
    localparam logic [1:0] CFG_ESCAPE_BYTE = 2'd1;
    localparam logic [1:0] CFG_ESCAPE_MASK = 2'd2;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd3;

    localparam logic [7:0]  RST_START_BYTE  = 8'h7E;
    localparam logic [7:0]  RST_ESCAPE_BYTE = 8'h7D;
    localparam logic [7:0]  RST_ESCAPE_MASK = 8'h20;
    localparam logic [15:0] RST_MAX_PAYLOAD = 16'hFFFF;

    // Result item kinds and frame status codes
    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_STATUS  = 1'b1;
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CRC_ERR   = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // One byte of CRC-16/CCITT-FALSE, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/scfd_channels.sv -----
// Handshake channels of the frame decoder: received bytes, results, configuration
`default_nettype none

interface scfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfd_res_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  data_byte;
    logic [1:0]  frame_status;
    logic [15:0] frame_length;
    logic        last;

    modport source (output valid, output item_kind, output data_byte,
                    output frame_status, output frame_length, output last,
                    input ready);
    modport sink   (input valid, input item_kind, input data_byte,
                    input frame_status, input frame_length, input last,
                    output ready);
endinterface

interface scfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/scfd_fifo.sv -----
// Small flop-based queue between the framing front end and the back end
`default_nettype none

module scfd_fifo #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/scfd_front.sv -----
// Front end: start hunting, escape removal, length check and byte tagging
`default_nettype none

module scfd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scfd_pkg::t_cfg  i_cfg,
    scfd_rx_if.sink         i_rx,
    input  logic            i_q_full,
    output logic            o_push,
    output scfd_pkg::t_token o_token
);
    import scfd_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_esc, n_esc;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_remaining, n_remaining;
    logic        accept;
    logic        have_byte;
    logic [7:0]  b;
    logic [15:0] len_full;

    assign i_rx.ready = !i_q_full;
    assign accept     = i_rx.valid && !i_q_full;
    assign b          = r_esc ? (i_rx.rx_byte ^ i_cfg.escape_mask) : i_rx.rx_byte;
    assign have_byte  = r_esc || (i_rx.rx_byte != i_cfg.escape_byte);
    assign len_full   = {r_len_hi, b};

    always_comb begin
        n_phase       = r_phase;
        n_esc         = r_esc;
        n_len_hi      = r_len_hi;
        n_remaining   = r_remaining;
        o_push        = 1'b0;
        o_token.kind  = TK_PAYLOAD;
        o_token.data  = b;
        if (accept) begin
            if (r_phase inside {PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD, PH_CRC_HI, PH_CRC_LO}) begin
                // an escaped escape byte is data, never a second escape
                n_esc = !r_esc && (i_rx.rx_byte == i_cfg.escape_byte);
                if (have_byte) begin
                    o_push = 1'b1;
                    case (r_phase)
                        PH_LEN_HI: begin
                            o_token.kind = TK_LEN_HI;
                            n_len_hi     = b;
                            n_phase      = PH_LEN_LO;
                        end
                        PH_LEN_LO: begin
                            if (len_full > i_cfg.max_payload) begin
                                o_token.kind = TK_LEN_BAD;
                                n_phase      = PH_HUNT;
                            end else begin
                                o_token.kind = TK_LEN_LO;
                                n_remaining  = len_full;
                                n_phase      = (len_full == 16'd0) ? PH_CRC_HI : PH_PAYLOAD;
                            end
                        end
                        PH_PAYLOAD: begin
                            o_token.kind = TK_PAYLOAD;
                            n_remaining  = r_remaining - 16'd1;
                            if (r_remaining == 16'd1) begin
                                n_phase = PH_CRC_HI;
                            end
                        end
                        PH_CRC_HI: begin
                            o_token.kind = TK_CRC_HI;
                            n_phase      = PH_CRC_LO;
                        end
                        default: begin
                            o_token.kind = TK_CRC_LO;
                            n_phase      = PH_HUNT;
                        end
                    endcase
                end
            end else begin
                // hunting: drop everything but the start byte
                n_phase = PH_HUNT;
                if (i_rx.rx_byte == i_cfg.start_byte) begin
                    n_phase = PH_LEN_HI;
                    n_esc   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_esc   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len_hi    <= n_len_hi;
        r_remaining <= n_remaining;
    end

endmodule

`default_nettype wire

// ----- src/scfd_back.sv -----
// Back end: CRC accumulation, result building and the output register
`default_nettype none

module scfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  scfd_pkg::t_token i_token,
    output logic             o_pop,
    scfd_res_if.source       o_res
);
    import scfd_pkg::*;

    logic [15:0] r_len, n_len;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_hi, n_crc_hi;
    logic        r_valid, n_valid;
    logic        r_kind, n_kind;
    logic [7:0]  r_data, n_data;
    logic [1:0]  r_status, n_status;
    logic [15:0] r_flen, n_flen;
    logic        emits;
    logic        out_free;
    logic [15:0] crc_next;

    assign emits    = (i_token.kind == TK_LEN_BAD) || (i_token.kind == TK_PAYLOAD)
                   || (i_token.kind == TK_CRC_LO);
    assign out_free = !r_valid || o_res.ready;
    assign o_pop    = i_q_valid && (!emits || out_free);
    // restart the CRC on the first length byte of each frame
    assign crc_next = crc16_byte((i_token.kind == TK_LEN_HI) ? CRC_INIT : r_crc,
                                 i_token.data);

    always_comb begin
        n_len    = r_len;
        n_crc    = r_crc;
        n_crc_hi = r_crc_hi;
        n_valid  = r_valid && !o_res.ready;
        n_kind   = r_kind;
        n_data   = r_data;
        n_status = r_status;
        n_flen   = r_flen;
        if (o_pop) begin
            case (i_token.kind)
                TK_LEN_HI: begin
                    n_len = {i_token.data, r_len[7:0]};
                    n_crc = crc_next;
                end
                TK_LEN_LO: begin
                    n_len = {r_len[15:8], i_token.data};
                    n_crc = crc_next;
                end
                TK_LEN_BAD: begin
                    n_valid  = 1'b1;
                    n_kind   = KIND_STATUS;
                    n_data   = 8'd0;
                    n_status = ST_TOO_LONG;
                    n_flen   = {r_len[15:8], i_token.data};
                end
                TK_PAYLOAD: begin
                    n_crc    = crc_next;
                    n_valid  = 1'b1;
                    n_kind   = KIND_PAYLOAD;
                    n_data   = i_token.data;
                    n_status = ST_OK;
                    n_flen   = r_len;
                end
                TK_CRC_HI: begin
                    n_crc_hi = i_token.data;
                end
                TK_CRC_LO: begin
                    n_valid  = 1'b1;
                    n_kind   = KIND_STATUS;
                    n_data   = 8'd0;
                    n_status = ({r_crc_hi, i_token.data} == r_crc) ? ST_OK : ST_CRC_ERR;
                    n_flen   = r_len;
                end
                default: begin
                    n_len = r_len;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_crc    <= n_crc;
        r_crc_hi <= n_crc_hi;
        r_kind   <= n_kind;
        r_data   <= n_data;
        r_status <= n_status;
        r_flen   <= n_flen;
    end

    assign o_res.valid        = r_valid;
    assign o_res.item_kind    = r_kind;
    assign o_res.data_byte    = r_data;
    assign o_res.frame_status = r_status;
    assign o_res.frame_length = r_flen;
    assign o_res.last         = r_kind;

endmodule

`default_nettype wire

// ----- src/stuffed_crc_frame_decoder_unit.sv -----
// Top level: byte-stuffed frame decoder with CRC-16 check
// A result is registered in the output register after its byte has passed the token queue.
// Throughput: one received byte per cycle, set by the one-byte CRC update in the back end.
// The front stalls only when the token queue (QUEUE_DEPTH entries) is full.
// Reset: phase returns to hunting, queue and output register empty, config takes defaults.
// No clearing pass after reset; configuration writes are taken in every cycle.
`default_nettype none

module stuffed_crc_frame_decoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scfd_rx_if.sink    i_rx,
    scfd_res_if.source o_res,
    scfd_cfg_if.sink   i_cfg
);
    import scfd_pkg::*;

    t_cfg               r_cfg, n_cfg;
    logic               q_push;
    t_token             push_token;
    logic               q_full;
    logic               q_pop;
    logic [TOKEN_W-1:0] q_data;
    logic               q_valid;
    t_token             head_token;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_START_BYTE:  n_cfg.start_byte  = i_cfg.data[7:0];
                CFG_ESCAPE_BYTE: n_cfg.escape_byte = i_cfg.data[7:0];
                CFG_ESCAPE_MASK: n_cfg.escape_mask = i_cfg.data[7:0];
                CFG_MAX_PAYLOAD: n_cfg.max_payload = i_cfg.data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte  <= RST_START_BYTE;
            r_cfg.escape_byte <= RST_ESCAPE_BYTE;
            r_cfg.escape_mask <= RST_ESCAPE_MASK;
            r_cfg.max_payload <= RST_MAX_PAYLOAD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    scfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_rx     (i_rx),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_token  (push_token)
    );

    scfd_fifo #(
        .WIDTH (TOKEN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_token),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_valid (q_valid)
    );

    assign head_token = t_token'(q_data);

    scfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_token   (head_token),
        .o_pop     (q_pop),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

// ----- src/scfd_checker.sv -----
// Port-level checker for the frame decoder, bound to the top level
`default_nettype none
`include "stuffed_crc_frame_decoder_unit_defines.svh"

module scfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_item_kind,
    input logic [7:0]  i_data_byte,
    input logic [1:0]  i_frame_status,
    input logic [15:0] i_frame_length,
    input logic        i_last
);
    import scfd_pkg::*;

    logic [27:0] res_word;
    logic        is_payload;
    logic        is_status;
    logic        status_code_ok;

    assign res_word       = {i_item_kind, i_data_byte, i_frame_status, i_frame_length, i_last};
    assign is_payload     = i_res_valid && (i_item_kind == KIND_PAYLOAD);
    assign is_status      = i_res_valid && (i_item_kind == KIND_STATUS);
    assign status_code_ok = (i_frame_status == ST_OK) || (i_frame_status == ST_CRC_ERR)
                         || (i_frame_status == ST_TOO_LONG);

    // a stalled result holds
    `SCFD_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(res_word))

    // nothing is shown straight after reset
    `SCFD_ASSERT_IMPL(a_quiet_after_reset, $past(!i_rst_n), !i_res_valid)

    // only a status item closes a frame
    `SCFD_ASSERT_IMPL(a_last_is_status, i_res_valid, i_last == i_item_kind)

    // payload items carry the OK status code
    `SCFD_ASSERT_IMPL(a_payload_ok, is_payload, i_frame_status == ST_OK)

    // status items carry a zero byte and a defined code
    `SCFD_ASSERT_IMPL(a_status_form, is_status, (i_data_byte == 8'd0) && status_code_ok)

endmodule

bind stuffed_crc_frame_decoder_unit scfd_checker u_scfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_item_kind    (o_res.item_kind),
    .i_data_byte    (o_res.data_byte),
    .i_frame_status (o_res.frame_status),
    .i_frame_length (o_res.frame_length),
    .i_last         (o_res.last)
);

`default_nettype wire
